>>> src/irp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irp_pkg: shared types and constants of the idle residency profiler
// Payload structs, action and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package irp_pkg;

    localparam int DEF_NUM_CPUS        = 8;
    localparam int DEF_NUM_IDLE_STATES = 4;
    localparam int DEF_NUM_BINS        = 32;
    localparam int DEF_NUM_CLUSTERS    = 3;
    localparam int NUM_CLUSTER_REGS    = 3;

    localparam logic [2:0] ACT_ENTER = 3'd0;
    localparam logic [2:0] ACT_EXIT  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_LOAD  = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_IGNORED     = 3'd1;
    localparam logic [2:0] STS_ALREADY     = 3'd2;
    localparam logic [2:0] STS_NOT_STARTED = 3'd3;
    localparam logic [2:0] STS_NO_ENTRY    = 3'd4;

    localparam logic [1:0] REG_CLUSTER0 = 2'd0;
    localparam logic [1:0] REG_CLUSTER1 = 2'd1;
    localparam logic [1:0] REG_CLUSTER2 = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  cpu;
        logic [1:0]  state_index;
        logic        cancel;
        logic [21:0] freq_khz;
        logic [1:0]  cluster_sel;
        logic [4:0]  bin;
        logic [47:0] now_us;
    } irp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] residency_us;
        logic [31:0] entry_total;
        logic [31:0] cancel_total;
        logic [47:0] profile_length_us;
        logic        running;
    } irp_out_t;

    typedef struct packed {
        logic [47:0] stamp;
        logic        valid;
        logic [47:0] residency;
        logic [31:0] entries;
        logic [31:0] cancels;
    } irp_stat_t;

    typedef enum logic [2:0] {
        OPC_NONE,
        OPC_ENTER,
        OPC_EXIT,
        OPC_READ,
        OPC_START
    } irp_opc_t;

    typedef struct packed {
        logic capture;
        logic do_imm;
        logic clr_init;
        logic clr_step;
        logic clr_all;
        logic lef_rd;
        logic srch_init;
        logic key_lef;
        logic ftab_rd;
        logic srch_next;
        logic srch_done;
        logic stat_rd;
        logic stat_mod;
        logic emit;
    } irp_cmd_t;

    typedef struct packed {
        irp_opc_t opc;
        logic     clr_last;
        logic     bin_match;
        logic     bin_last;
        logic     out_full;
    } irp_sts_t;

endpackage
`default_nettype wire

>>> src/irp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irp_ctrl: sequencer of the idle residency profiler
// Steps each accepted beat through decode, bin search, statistics
// read-modify-write and result hand-off; runs the memory clearing sweeps.
// ----------------------------------------------------------------------------
module irp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire irp_pkg::irp_sts_t sts,
    output irp_pkg::irp_cmd_t      cmd
);
    import irp_pkg::*;

    typedef enum logic [3:0] {
        S_CLR_ALL, S_IDLE, S_DECODE, S_CLR_STAT, S_LEF_RD, S_LEF_WAIT,
        S_SRCH_RD, S_SRCH_CMP, S_STAT_RD, S_STAT_MOD, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_ALL;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR_ALL: begin
                cmd.clr_step = 1'b1;
                cmd.clr_all  = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.opc)
                    OPC_ENTER: begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_SRCH_RD;
                    end
                    OPC_EXIT:  state_next = S_LEF_RD;
                    OPC_READ:  state_next = S_STAT_RD;
                    OPC_START: begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLR_STAT;
                    end
                    default: begin
                        cmd.do_imm = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLR_STAT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_DONE;
            end
            S_LEF_RD: begin
                cmd.lef_rd = 1'b1;
                state_next = S_LEF_WAIT;
            end
            S_LEF_WAIT: begin
                cmd.srch_init = 1'b1;
                cmd.key_lef   = 1'b1;
                state_next    = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                cmd.ftab_rd = 1'b1;
                state_next  = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (sts.bin_match || sts.bin_last) begin
                    cmd.srch_done = 1'b1;
                    state_next    = S_STAT_RD;
                end else begin
                    cmd.srch_next = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_STAT_RD: begin
                cmd.stat_rd = 1'b1;
                state_next  = S_STAT_MOD;
            end
            S_STAT_MOD: begin
                cmd.stat_mod = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The statistics update always uses data fetched in the cycle before.
    a_mod_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.stat_mod |-> $past(cmd.stat_rd))
        else $error("statistics update without a preceding read");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> !cmd.emit && s_ready)
        else $error("result emitted twice for one beat");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.emit, cmd.clr_step, cmd.stat_mod, cmd.ftab_rd}))
        else $error("conflicting datapath commands");

    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !s_ready)
        else $error("input accepted during a clearing sweep");

endmodule
`default_nettype wire

>>> src/irp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irp_dp: datapath of the idle residency profiler
// Holds the frequency table, last-enter frequencies and statistics memories,
// the profile registers and the output register.
// ----------------------------------------------------------------------------
module irp_dp #(
    parameter int NUM_CPUS        = irp_pkg::DEF_NUM_CPUS,
    parameter int NUM_IDLE_STATES = irp_pkg::DEF_NUM_IDLE_STATES,
    parameter int NUM_BINS        = irp_pkg::DEF_NUM_BINS,
    parameter int NUM_CLUSTERS    = irp_pkg::DEF_NUM_CLUSTERS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire irp_pkg::irp_in_t  s_data,
    input  wire logic [2:0][2:0]   cluster_last,
    input  wire irp_pkg::irp_cmd_t cmd,
    output irp_pkg::irp_sts_t      sts,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output irp_pkg::irp_out_t      m_data
);
    import irp_pkg::*;

    localparam int STAT_DEPTH = NUM_IDLE_STATES * NUM_CPUS * NUM_BINS;
    localparam int LEF_DEPTH  = NUM_IDLE_STATES * NUM_CPUS;
    localparam int FT_DEPTH   = NUM_CLUSTERS * NUM_BINS;
    localparam int SWEEP_ALL  = (STAT_DEPTH > FT_DEPTH) ? STAT_DEPTH : FT_DEPTH;
    localparam int SA_W  = (STAT_DEPTH > 1) ? $clog2(STAT_DEPTH) : 1;
    localparam int LA_W  = (LEF_DEPTH > 1) ? $clog2(LEF_DEPTH) : 1;
    localparam int FA_W  = (FT_DEPTH > 1) ? $clog2(FT_DEPTH) : 1;
    localparam int CI_W  = (SWEEP_ALL > 1) ? $clog2(SWEEP_ALL) : 1;
    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CL_W  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

    irp_stat_t   stat_mem [STAT_DEPTH];
    logic [21:0] lef_mem  [LEF_DEPTH];
    logic [21:0] ft_mem   [FT_DEPTH];

    irp_in_t     in_reg;
    irp_stat_t   stat_q;
    logic [21:0] lef_q, ft_q, key_reg;
    logic [BIN_W-1:0] cnt_reg, bin_reg;
    logic [CI_W-1:0]  clr_idx_reg;
    logic        on_reg;
    logic [47:0] start_reg, plen_reg;
    logic [2:0]  status_reg;
    logic [47:0] resv_reg;
    logic [31:0] ent_reg, can_reg;
    logic        out_valid_reg;
    irp_out_t    out_reg;

    logic addr_ok, bin_ok, ft_load_ok;
    irp_opc_t opc;
    logic [2:0] imm_status;
    logic [CL_W-1:0] cl;
    logic cl_found;
    logic [31:0] fi_full, k_full, fa_full, la_full, bin_use;
    irp_stat_t stat_w;
    logic stat_we;
    logic [2:0] mod_status;

    always_ff @(posedge aclk) begin
        if (cmd.capture) in_reg <= s_data;
    end

    assign addr_ok = (32'(in_reg.cpu) < NUM_CPUS) && (32'(in_reg.state_index) < NUM_IDLE_STATES);
    assign bin_ok  = 32'(in_reg.bin) < NUM_BINS;
    assign ft_load_ok = (32'(in_reg.cluster_sel) < NUM_CLUSTERS) && bin_ok;

    always_comb begin
        opc        = OPC_NONE;
        imm_status = STS_OK;
        case (in_reg.action)
            ACT_ENTER: begin
                if (on_reg && addr_ok) opc = OPC_ENTER;
                if (!on_reg) imm_status = STS_IGNORED;
            end
            ACT_EXIT: begin
                if (on_reg && addr_ok) opc = OPC_EXIT;
                if (!on_reg) imm_status = STS_IGNORED;
            end
            ACT_START: begin
                if (!on_reg) opc = OPC_START;
                else imm_status = STS_ALREADY;
            end
            ACT_STOP: begin
                if (!on_reg) imm_status = STS_NOT_STARTED;
            end
            ACT_READ: begin
                if (addr_ok && bin_ok) opc = OPC_READ;
            end
            default: opc = OPC_NONE;
        endcase
    end

    // First cluster whose last cpu covers this cpu, cluster zero otherwise.
    always_comb begin
        cl       = '0;
        cl_found = 1'b0;
        for (int i = 0; i < NUM_CLUSTER_REGS; i++) begin
            if (!cl_found && i < NUM_CLUSTERS && in_reg.cpu <= cluster_last[i]) begin
                cl       = CL_W'(i);
                cl_found = 1'b1;
            end
        end
    end

    assign fi_full = 32'(in_reg.state_index) * NUM_CPUS + 32'(in_reg.cpu);
    assign bin_use = (opc == OPC_READ) ? 32'(in_reg.bin) : 32'(bin_reg);
    assign k_full  = fi_full * NUM_BINS + bin_use;
    assign fa_full = 32'(cl) * NUM_BINS + 32'(cnt_reg);
    assign la_full = 32'(in_reg.cluster_sel) * NUM_BINS + 32'(in_reg.bin);

    always_comb begin
        stat_w     = stat_q;
        stat_we    = 1'b0;
        mod_status = STS_OK;
        if (cmd.stat_mod) begin
            if (opc == OPC_ENTER) begin
                stat_w.stamp   = in_reg.now_us;
                stat_w.valid   = 1'b1;
                stat_w.entries = stat_q.entries + 32'd1;
                stat_we        = 1'b1;
            end else if (opc == OPC_EXIT) begin
                if (!stat_q.valid) begin
                    mod_status = STS_NO_ENTRY;
                end else if (in_reg.cancel) begin
                    stat_w.cancels = stat_q.cancels + 32'd1;
                    stat_we        = 1'b1;
                end else begin
                    stat_w.residency = stat_q.residency + (in_reg.now_us - stat_q.stamp);
                    stat_w.stamp     = '0;
                    stat_w.valid     = 1'b0;
                    stat_we          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            stat_mem[clr_idx_reg[SA_W-1:0]] <= '0;
        end else if (stat_we) begin
            stat_mem[k_full[SA_W-1:0]] <= stat_w;
        end
        if (cmd.stat_rd) stat_q <= stat_mem[k_full[SA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step && cmd.clr_all && 32'(clr_idx_reg) < LEF_DEPTH) begin
            lef_mem[clr_idx_reg[LA_W-1:0]] <= '0;
        end else if (cmd.stat_mod && opc == OPC_ENTER) begin
            lef_mem[fi_full[LA_W-1:0]] <= in_reg.freq_khz;
        end
        if (cmd.lef_rd) lef_q <= lef_mem[fi_full[LA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step && cmd.clr_all && 32'(clr_idx_reg) < FT_DEPTH) begin
            ft_mem[clr_idx_reg[FA_W-1:0]] <= '0;
        end else if (cmd.do_imm && in_reg.action == ACT_LOAD && ft_load_ok) begin
            ft_mem[la_full[FA_W-1:0]] <= in_reg.freq_khz;
        end
        if (cmd.ftab_rd) ft_q <= ft_mem[fa_full[FA_W-1:0]];
    end

    // Bin search state.
    always_ff @(posedge aclk) begin
        if (cmd.srch_init) begin
            key_reg <= cmd.key_lef ? lef_q : in_reg.freq_khz;
            cnt_reg <= '0;
        end else if (cmd.srch_next) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.srch_done) bin_reg <= sts.bin_match ? cnt_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg   <= '0;
            on_reg        <= 1'b0;
            start_reg     <= '0;
            plen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_init) begin
                clr_idx_reg <= '0;
                start_reg   <= in_reg.now_us;
                on_reg      <= 1'b1;
            end else if (cmd.clr_step && !sts.clr_last) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.do_imm && in_reg.action == ACT_STOP && on_reg) begin
                on_reg   <= 1'b0;
                plen_reg <= in_reg.now_us - start_reg;
            end
            if (cmd.emit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_imm || cmd.clr_init || cmd.capture) begin
            status_reg <= cmd.do_imm ? imm_status : STS_OK;
            resv_reg   <= '0;
            ent_reg    <= '0;
            can_reg    <= '0;
        end else if (cmd.stat_mod) begin
            status_reg <= mod_status;
            if (opc == OPC_READ) begin
                resv_reg <= stat_q.residency;
                ent_reg  <= stat_q.entries;
                can_reg  <= stat_q.cancels;
            end
        end
        if (cmd.emit) begin
            out_reg.status            <= status_reg;
            out_reg.residency_us      <= resv_reg;
            out_reg.entry_total       <= ent_reg;
            out_reg.cancel_total      <= can_reg;
            out_reg.profile_length_us <= plen_reg;
            out_reg.running           <= on_reg;
        end
    end

    assign sts.opc       = opc;
    assign sts.clr_last  = cmd.clr_all ? (32'(clr_idx_reg) == SWEEP_ALL - 1)
                                       : (32'(clr_idx_reg) == STAT_DEPTH - 1);
    assign sts.bin_match = (ft_q == key_reg);
    assign sts.bin_last  = (32'(cnt_reg) == NUM_BINS - 1);
    assign sts.out_full  = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

>>> src/idle_residency_profiler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idle_residency_profiler: per-CPU idle residency statistics
// Counts idle entries, cancels and residency by idle state and frequency bin.
// ----------------------------------------------------------------------------
// Usage: events and commands arrive as beats on the s_ channel (valid/ready);
// every beat yields exactly one result beat on the m_ channel. The three
// cluster boundary registers sit on the APB port at byte addresses 0, 4, 8
// and the user must write them only while the block is idle; the block
// itself does not enforce this. Each beat passes decode; enters and exits
// then search the frequency table one entry at a time through its single
// registered read port up to a match or the last bin (an exit first reads
// its last-enter frequency), then the statistics entry is read and updated.
// A read goes straight to the statistics read; stop, load and ignored events
// go to the result. A start clears the statistics memory one entry per cycle.
// One beat is processed at a time; the next beat is taken as soon as the
// result sits in the output register, even if the receiver stalls it.
// After reset a clearing sweep over max(statistics depth, table depth) entries
// (1024 at the defaults) runs before s_ready rises; profiling is stopped.
// A stalled result is held; processing waits only if a second result is due.
// ----------------------------------------------------------------------------
module idle_residency_profiler #(
    parameter int NUM_CPUS        = irp_pkg::DEF_NUM_CPUS,
    parameter int NUM_IDLE_STATES = irp_pkg::DEF_NUM_IDLE_STATES,
    parameter int NUM_BINS        = irp_pkg::DEF_NUM_BINS,
    parameter int NUM_CLUSTERS    = irp_pkg::DEF_NUM_CLUSTERS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire irp_pkg::irp_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output irp_pkg::irp_out_t     m_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import irp_pkg::*;

    logic [2:0][2:0] cluster_last_reg;
    irp_cmd_t cmd;
    irp_sts_t sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_last_reg[0] <= 3'd3;
            cluster_last_reg[1] <= 3'd5;
            cluster_last_reg[2] <= 3'd7;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_CLUSTER0: cluster_last_reg[0] <= pwdata[2:0];
                REG_CLUSTER1: cluster_last_reg[1] <= pwdata[2:0];
                REG_CLUSTER2: cluster_last_reg[2] <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLUSTER0: prdata = {29'd0, cluster_last_reg[0]};
            REG_CLUSTER1: prdata = {29'd0, cluster_last_reg[1]};
            REG_CLUSTER2: prdata = {29'd0, cluster_last_reg[2]};
            default:      prdata = '0;
        endcase
    end

    irp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    irp_dp #(
        .NUM_CPUS        (NUM_CPUS),
        .NUM_IDLE_STATES (NUM_IDLE_STATES),
        .NUM_BINS        (NUM_BINS),
        .NUM_CLUSTERS    (NUM_CLUSTERS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .cluster_last (cluster_last_reg),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_data       (m_data)
    );

endmodule
`default_nettype wire

>>> tb/tb_idle_residency_profiler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idle_residency_profiler: self-checking bench of the idle residency profiler
// Drives event, control, load and read beats with bursty timing. A local
// statistics predictor computes each result beat, which is compared field by
// field as it leaves the block. Cluster boundaries are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_idle_residency_profiler;
    import irp_pkg::*;

    localparam int NCPU   = 8;
    localparam int NSTATE = 4;
    localparam int NBIN   = 32;
    localparam int NCLUS  = 3;
    localparam int DEPTH  = NSTATE * NCPU * NBIN;
    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    irp_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    irp_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    idle_residency_profiler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Predictor state.
    logic [2:0]  last_cpu_of [NCLUS];
    logic [21:0] freq_tab [NCLUS][NBIN];
    logic [47:0] stamp_mem [DEPTH];
    logic        stamp_ok [DEPTH];
    logic [47:0] resid_mem [DEPTH];
    logic [31:0] enter_cnt [DEPTH];
    logic [31:0] cancel_cnt [DEPTH];
    logic [21:0] enter_freq [NSTATE*NCPU];
    logic        prof_on;
    logic [47:0] prof_start;
    logic [47:0] prof_len;

    irp_in_t  beat_queue[$];
    irp_out_t expected_results[$];
    int       failures = 0;
    int       idle_cycles = 0;

    // Values used by the random part so that frequencies hit the tables often.
    logic [21:0] freq_pool [8];

    function automatic int cluster_of(logic [2:0] cpu);
        for (int i = 0; i < NCLUS; i++)
            if (cpu <= last_cpu_of[i]) return i;
        return 0;
    endfunction

    function automatic int bin_of(int cl, logic [21:0] f);
        for (int i = 0; i < NBIN; i++)
            if (freq_tab[cl][i] == f) return i;
        return 0;
    endfunction

    function automatic irp_out_t predict_stats(irp_in_t b);
        irp_out_t r;
        int fi, k;
        logic [47:0] d;
        r = '0;
        fi = b.state_index * NCPU + b.cpu;
        case (b.action)
            ACT_ENTER, ACT_EXIT: begin
                if (!prof_on) begin
                    r.status = STS_IGNORED;
                end else if (b.action == ACT_ENTER) begin
                    enter_freq[fi] = b.freq_khz;
                    k = fi * NBIN + bin_of(cluster_of(b.cpu), b.freq_khz);
                    stamp_mem[k] = b.now_us;
                    stamp_ok[k] = 1'b1;
                    enter_cnt[k] = enter_cnt[k] + 1;
                end else begin
                    k = fi * NBIN + bin_of(cluster_of(b.cpu), enter_freq[fi]);
                    if (!stamp_ok[k]) begin
                        r.status = STS_NO_ENTRY;
                    end else if (b.cancel) begin
                        cancel_cnt[k] = cancel_cnt[k] + 1;
                    end else begin
                        d = b.now_us - stamp_mem[k];
                        resid_mem[k] = resid_mem[k] + d;
                        stamp_mem[k] = '0;
                        stamp_ok[k] = 1'b0;
                    end
                end
            end
            ACT_START: begin
                if (prof_on) begin
                    r.status = STS_ALREADY;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        stamp_mem[i] = '0; stamp_ok[i] = 1'b0; resid_mem[i] = '0;
                        enter_cnt[i] = '0; cancel_cnt[i] = '0;
                    end
                    prof_start = b.now_us;
                    prof_on = 1'b1;
                end
            end
            ACT_STOP: begin
                if (!prof_on) begin
                    r.status = STS_NOT_STARTED;
                end else begin
                    prof_on = 1'b0;
                    prof_len = b.now_us - prof_start;
                end
            end
            ACT_LOAD: begin
                if (b.cluster_sel < NCLUS) freq_tab[b.cluster_sel][b.bin] = b.freq_khz;
            end
            ACT_READ: begin
                k = fi * NBIN + b.bin;
                r.residency_us = resid_mem[k];
                r.entry_total = enter_cnt[k];
                r.cancel_total = cancel_cnt[k];
            end
            default: ;
        endcase
        r.profile_length_us = prof_len;
        r.running = prof_on;
        return r;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    // The front of the queue is always the beat on the bus or the next to go.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_stats(s_data));
                void'(beat_queue.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (beat_queue.size() > 0) begin
                s_data <= beat_queue[0];
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall pattern.
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat");
                    failures++;
                end else begin
                    irp_out_t e;
                    e = expected_results.pop_front();
                    if (m_data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_data.status); failures++;
                    end
                    if (m_data.residency_us !== e.residency_us) begin
                        $error("residency_us exp %0d got %0d", e.residency_us,
                               m_data.residency_us); failures++;
                    end
                    if (m_data.entry_total !== e.entry_total) begin
                        $error("entry_total exp %0d got %0d", e.entry_total,
                               m_data.entry_total); failures++;
                    end
                    if (m_data.cancel_total !== e.cancel_total) begin
                        $error("cancel_total exp %0d got %0d", e.cancel_total,
                               m_data.cancel_total); failures++;
                    end
                    if (m_data.profile_length_us !== e.profile_length_us) begin
                        $error("profile_length_us exp %0d got %0d", e.profile_length_us,
                               m_data.profile_length_us); failures++;
                    end
                    if (m_data.running !== e.running) begin
                        $error("running exp %0d got %0d", e.running, m_data.running);
                        failures++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            if (stall_phase < 6) m_ready <= 1'b1;
            else if (stall_phase < 10) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("idle_residency_profiler: mismatch");
            $finish;
        end
    end

    task automatic write_boundary(logic [1:0] idx, logic [2:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {29'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        last_cpu_of[idx] = val;
    endtask

    task automatic wait_drained();
        while (beat_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    function automatic irp_in_t make_beat(logic [2:0] act, logic [2:0] cpu, logic [1:0] st,
                                          logic cn, logic [21:0] f, logic [1:0] cs,
                                          logic [4:0] bn, logic [47:0] now);
        irp_in_t b;
        b.action = act; b.cpu = cpu; b.state_index = st; b.cancel = cn;
        b.freq_khz = f; b.cluster_sel = cs; b.bin = bn; b.now_us = now;
        return b;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic irp_in_t random_beat(logic [47:0] now);
        irp_in_t b;
        int pick;
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        b = raw[$bits(irp_in_t)-1:0];
        b.now_us = now;
        b.freq_khz = ($urandom_range(0, 5) == 0) ? b.freq_khz : freq_pool[$urandom_range(0, 7)];
        pick = $urandom_range(0, 99);
        if (pick < 38) b.action = ACT_ENTER;
        else if (pick < 74) b.action = ACT_EXIT;
        else if (pick < 77) b.action = ACT_START;
        else if (pick < 80) b.action = ACT_STOP;
        else if (pick < 86) b.action = ACT_LOAD;
        else if (pick < 97) b.action = ACT_READ;
        else b.action = 3'($urandom_range(6, 7));
        return b;
    endfunction

    logic [47:0] clock_us;

    initial begin
        irp_in_t b;
        last_cpu_of[0] = 3; last_cpu_of[1] = 5; last_cpu_of[2] = 7;
        foreach (freq_tab[c, i]) freq_tab[c][i] = '0;
        for (int i = 0; i < DEPTH; i++) begin
            stamp_mem[i] = '0; stamp_ok[i] = 1'b0; resid_mem[i] = '0;
            enter_cnt[i] = '0; cancel_cnt[i] = '0;
        end
        foreach (enter_freq[i]) enter_freq[i] = '0;
        prof_on = 1'b0; prof_start = '0; prof_len = '0;
        for (int i = 0; i < 8; i++) freq_pool[i] = 22'($urandom());
        freq_pool[0] = '0; freq_pool[1] = 22'h3FFFFF;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_boundary(REG_CLUSTER0, 3'd1);
        write_boundary(REG_CLUSTER1, 3'd4);
        write_boundary(REG_CLUSTER2, 3'd7);

        // Directed part.
        beat_queue.push_back(make_beat(ACT_ENTER, 0, 0, 0, 0, 0, 0, 48'd5));
        beat_queue.push_back(make_beat(ACT_STOP, 0, 0, 0, 0, 0, 0, 48'd6));
        beat_queue.push_back(make_beat(ACT_LOAD, 0, 0, 0, 22'h3FFFFF, 0, 31, 48'd7));
        beat_queue.push_back(make_beat(ACT_LOAD, 0, 0, 0, 22'd1200, 1, 0, 48'd7));
        beat_queue.push_back(make_beat(ACT_LOAD, 0, 0, 0, 22'd1, 3, 4, 48'd7));
        beat_queue.push_back(make_beat(ACT_START, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFF0));
        beat_queue.push_back(make_beat(ACT_START, 0, 0, 0, 0, 0, 0, 48'd1));
        beat_queue.push_back(make_beat(ACT_EXIT, 7, 3, 1, 0, 0, 0, 48'd2));
        beat_queue.push_back(make_beat(ACT_ENTER, 0, 0, 0, 22'h3FFFFF, 0, 0,
                                       48'hFFFF_FFFF_FFFF));
        beat_queue.push_back(make_beat(ACT_EXIT, 0, 0, 1, 0, 0, 0, 48'd3));
        beat_queue.push_back(make_beat(ACT_EXIT, 0, 0, 0, 0, 0, 0, 48'd9));
        beat_queue.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 31, 48'd9));
        beat_queue.push_back(make_beat(ACT_ENTER, 7, 3, 0, 22'd1200, 0, 0, 48'd10));
        beat_queue.push_back(make_beat(ACT_ENTER, 7, 3, 0, 22'd77, 0, 0, 48'd11));
        beat_queue.push_back(make_beat(ACT_EXIT, 7, 3, 0, 22'd77, 0, 0, 48'd50));
        beat_queue.push_back(make_beat(ACT_READ, 7, 3, 1, 22'h3FFFFF, 2, 0, 48'd50));
        beat_queue.push_back(make_beat(3'd6, 7, 3, 1, 0, 0, 0, 48'd51));
        beat_queue.push_back(make_beat(3'd7, 0, 0, 0, 0, 0, 0, 48'd51));
        beat_queue.push_back(make_beat(ACT_STOP, 0, 0, 0, 0, 0, 0, 48'd100));
        beat_queue.push_back(make_beat(ACT_STOP, 0, 0, 0, 0, 0, 0, 48'd101));
        beat_queue.push_back(make_beat(ACT_READ, 4, 2, 0, 0, 0, 15, 48'd101));
        wait_drained();

        // Random phases with different cluster boundaries.
        clock_us = rand48();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_boundary(REG_CLUSTER0, 3'd0);
                    write_boundary(REG_CLUSTER1, 3'd0);
                    write_boundary(REG_CLUSTER2, 3'd0);
                end
                2: begin
                    write_boundary(REG_CLUSTER0, 3'd7);
                    write_boundary(REG_CLUSTER1, 3'd7);
                    write_boundary(REG_CLUSTER2, 3'd7);
                end
                3, 4: begin
                    write_boundary(REG_CLUSTER0, 3'($urandom()));
                    write_boundary(REG_CLUSTER1, 3'($urandom()));
                    write_boundary(REG_CLUSTER2, 3'($urandom()));
                end
                default: ;
            endcase
            // Keep profiling on for most beats, loading a few table entries first.
            for (int i = 0; i < 6; i++)
                beat_queue.push_back(make_beat(ACT_LOAD, 0, 0, 0, freq_pool[$urandom_range(0, 7)],
                                               2'($urandom_range(0, 2)),
                                               5'($urandom()), clock_us));
            beat_queue.push_back(make_beat(ACT_START, 0, 0, 0, 0, 0, 0, clock_us));
            for (int i = 0; i < 120; i++) begin
                clock_us = ($urandom_range(0, 30) == 0) ? rand48()
                                                        : clock_us + $urandom_range(0, 5000);
                b = random_beat(clock_us);
                if (b.action == ACT_START && $urandom_range(0, 1) == 0) b.action = ACT_READ;
                // Reads target bins that were recently touched more often.
                if (b.action == ACT_READ && $urandom_range(0, 1) == 0) begin
                    b.bin = 5'(bin_of(cluster_of(b.cpu),
                                      enter_freq[b.state_index * NCPU + b.cpu]));
                end
                beat_queue.push_back(b);
            end
            beat_queue.push_back(make_beat(ACT_STOP, 0, 0, 0, 0, 0, 0, clock_us + 48'd1));
            wait_drained();
        end

        if (failures == 0) begin
            $display("idle_residency_profiler: match");
        end else begin
            $display("idle_residency_profiler: mismatch");
        end
        $finish;
    end

endmodule
